// ===== hdl/pip_pkg.sv =====
// shared constants, codes and control structs for the point-in-polygon tester
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int VCOUNT_W     = 7;
    localparam int MIN_VERTICES = 3;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    // control that travels alongside each vertex read into the edge unit
    typedef struct packed {
        logic clear;
        logic vld;
        logic first;
        logic last;
    } t_edge_req;

    typedef struct packed {
        logic done;
        logic in_poly;
    } t_edge_rsp;

endpackage

`default_nettype wire

// ===== hdl/point_in_polygon_test.sv =====
// top level of the even-odd point-in-polygon tester: sequencer, vertex table, result regs
// depends on pip_pkg, pip_ram, pip_edge
//
// usage:
//   a request is taken at a rising edge where i_start is high and o_busy is low.
//   i_action selects clear table, append vertex (i_coord_x, i_coord_y) or query
//   the point (i_coord_x, i_coord_y). every request gives exactly one result, shown
//   for one cycle with o_done high: o_inside_res, o_status, o_vertex_count.
//   clear, append, unused codes and a query on fewer than three vertices answer
//   in the cycle after the request; o_busy stays low, so one request per cycle.
//   a query on n >= 3 vertices holds o_busy high until it answers, so no new
//   request is taken while it runs. its walk is bound by the single vertex table
//   read port: the edge unit walks one edge per cycle (n + 1 reads, the last
//   vertex first), then three pipeline stages drain.
//   results cannot be held off: o_done is a strobe and the receiver must take it.
//   synchronous reset empties the table (count zero) and drops any query in flight;
//   table contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic [1:0]                            i_action,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0] i_coord_y,
    output logic                                       o_done,
    output logic                                       o_inside_res,
    output logic [1:0]                                 o_status,
    output logic [pip_pkg::VCOUNT_W-1:0]               o_vertex_count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CB = pip_pkg::COORD_BITS;
    localparam int VW = 2 * CB;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_idx, n_idx;
    logic                   r_first, n_first;
    logic signed [CB-1:0]   r_px, n_px, r_py, n_py;
    pip_pkg::t_edge_req     r_edge_req, n_edge_req;
    logic                   r_done, n_done;
    logic                   r_inside, n_inside;
    logic [1:0]             r_status, n_status;
    logic [pip_pkg::VCOUNT_W-1:0] r_vcount, n_vcount;

    logic                   accept;
    logic                   full;
    logic                   we;
    logic [CW-1:0]          count_m1;
    logic [AW-1:0]          last_addr;
    logic [AW-1:0]          raddr;
    logic [VW-1:0]          rdata;
    pip_pkg::t_edge_rsp     edge_rsp;

    assign accept    = i_start && (r_state == S_IDLE);
    assign full      = r_count >= CW'(MAX_VERTICES);
    assign we        = accept && (i_action == pip_pkg::ACT_APPEND) && !full;
    assign count_m1  = r_count - 1'b1;
    assign last_addr = count_m1[AW-1:0];
    // closing edge first: read the last vertex, then 0 .. n-1
    assign raddr     = r_first ? last_addr : r_idx;

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_edge_req),
        .i_vx    (rdata[VW-1:CB]),
        .i_vy    (rdata[CB-1:0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_rsp   (edge_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_first    = r_first;
        n_px       = r_px;
        n_py       = r_py;
        n_edge_req = '0;
        n_done     = 1'b0;
        n_inside   = r_inside;
        n_status   = r_status;
        n_vcount   = r_vcount;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done   = 1'b1;
                    n_inside = 1'b0;
                    n_status = pip_pkg::ST_OK;
                    case (i_action)
                        pip_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        pip_pkg::ACT_APPEND: begin
                            if (full) begin
                                n_status = pip_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        pip_pkg::ACT_QUERY: begin
                            if (r_count < CW'(pip_pkg::MIN_VERTICES)) begin
                                n_status = pip_pkg::ST_DEGEN;
                            end else begin
                                n_done           = 1'b0;
                                n_state          = S_RUN;
                                n_first          = 1'b1;
                                n_idx            = '0;
                                n_px             = i_coord_x;
                                n_py             = i_coord_y;
                                n_edge_req.clear = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_vcount = pip_pkg::VCOUNT_W'(n_count);
                end
            end
            S_RUN: begin
                n_edge_req.vld   = 1'b1;
                n_edge_req.first = r_first;
                if (r_first) begin
                    n_first = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == last_addr) begin
                        n_edge_req.last = 1'b1;
                        n_state         = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (edge_rsp.done) begin
                    n_done   = 1'b1;
                    n_inside = edge_rsp.in_poly;
                    n_status = pip_pkg::ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_first    <= 1'b0;
            r_edge_req <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_first    <= n_first;
            r_edge_req <= n_edge_req;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_py     <= n_py;
        r_inside <= n_inside;
        r_status <= n_status;
        r_vcount <= n_vcount;
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_done         = r_done;
    assign o_inside_res   = r_inside;
    assign o_status       = r_status;
    assign o_vertex_count = r_vcount;

endmodule

`default_nettype wire

// ===== hdl/pip_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/pip_edge.sv =====
// edge crossing unit: one polygon edge per cycle, differences, products, compare
// depends on pip_pkg
`timescale 1ns / 1ps
`default_nettype none

module pip_edge (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire pip_pkg::t_edge_req                     i_req,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0]  i_vx,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0]  i_vy,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0]  i_px,
    input  wire logic signed [pip_pkg::COORD_BITS-1:0]  i_py,
    output pip_pkg::t_edge_rsp                          o_rsp
);

    localparam int CB = pip_pkg::COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    // previous vertex (edge start j), current vertex is i
    logic signed [CB-1:0] r_prev_x;
    logic signed [CB-1:0] r_prev_y;

    logic signed [DW-1:0] ext_vx, ext_vy, ext_px, ext_py, ext_jx, ext_jy;

    logic                 r_s1_vld, r_s1_last, r_s1_str;
    logic signed [DW-1:0] r_s1_dy, r_s1_dpx, r_s1_dxe, r_s1_dpy;

    logic                 r_s2_vld, r_s2_last, r_s2_str, r_s2_neg;
    logic signed [PW-1:0] r_s2_lhs, r_s2_rhs;

    logic                 r_flag;
    logic                 r_done;
    logic                 crossing;

    assign ext_vx = $signed({i_vx[CB-1], i_vx});
    assign ext_vy = $signed({i_vy[CB-1], i_vy});
    assign ext_px = $signed({i_px[CB-1], i_px});
    assign ext_py = $signed({i_py[CB-1], i_py});
    assign ext_jx = $signed({r_prev_x[CB-1], r_prev_x});
    assign ext_jy = $signed({r_prev_y[CB-1], r_prev_y});

    always_ff @(posedge i_clk) begin
        if (i_req.vld) begin
            r_prev_x <= i_vx;
            r_prev_y <= i_vy;
        end
        r_s1_str  <= (i_vy > i_py) != (r_prev_y > i_py);
        r_s1_dy   <= ext_jy - ext_vy;
        r_s1_dpx  <= ext_px - ext_vx;
        r_s1_dxe  <= ext_jx - ext_vx;
        r_s1_dpy  <= ext_py - ext_vy;
        r_s2_str  <= r_s1_str;
        r_s2_neg  <= r_s1_dy[DW-1];
        r_s2_lhs  <= PW'(r_s1_dpx) * PW'(r_s1_dy);
        r_s2_rhs  <= PW'(r_s1_dxe) * PW'(r_s1_dpy);
    end

    // reversed compare when yj - yi is negative, i.e. the edge from j rises to i
    assign crossing = r_s2_str && (r_s2_neg ? (r_s2_lhs > r_s2_rhs) : (r_s2_lhs < r_s2_rhs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
            r_flag    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_s1_vld  <= i_req.vld && !i_req.first;
            r_s1_last <= i_req.vld && i_req.last;
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            r_done    <= r_s2_vld && r_s2_last;
            if (i_req.clear) begin
                r_flag <= 1'b0;
            end else if (r_s2_vld && crossing) begin
                r_flag <= !r_flag;
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.in_poly = r_flag;

endmodule

`default_nettype wire

// ===== hdl/pip_check.sv =====
// port-level checks for the point-in-polygon tester, bound to the top level
// depends on pip_pkg and point_in_polygon_test
`timescale 1ns / 1ps
`default_nettype none

module pip_check (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_start,
    input wire logic                                  o_busy,
    input wire logic [1:0]                            i_action,
    input wire logic signed [pip_pkg::COORD_BITS-1:0] i_coord_x,
    input wire logic signed [pip_pkg::COORD_BITS-1:0] i_coord_y,
    input wire logic                                  o_done,
    input wire logic                                  o_inside_res,
    input wire logic [1:0]                            o_status,
    input wire logic [pip_pkg::VCOUNT_W-1:0]          o_vertex_count
);

    // anything but a query answers in the next cycle
    a_quick_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action != pip_pkg::ACT_QUERY)) |=> o_done)
        else $error("non-query request gave no result next cycle");

    // a query either answers at once or goes busy
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action == pip_pkg::ACT_QUERY)) |=> (o_busy || o_done))
        else $error("query neither answered nor started");

    // finishing a walk always delivers its result
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_busy)) |-> o_done)
        else $error("busy dropped without a result");

    // inside only with an ok status
    a_inside_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inside_res) |-> (o_status == pip_pkg::ST_OK))
        else $error("inside reported with error status");

    a_degen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == pip_pkg::ST_DEGEN))
            |-> (o_vertex_count < pip_pkg::VCOUNT_W'(pip_pkg::MIN_VERTICES)))
        else $error("degenerate status with enough vertices");

endmodule

bind point_in_polygon_test pip_check u_pip_check (.*);

`default_nettype wire

// ===== tb/sv/point_in_polygon_test_tb.sv =====
// self-checking testbench for the even-odd point-in-polygon tester
// drives clear, append, query and unused requests; checks answers with an in-bench polygon model
// depends on pip_pkg and point_in_polygon_test
`timescale 1ns / 1ps

module point_in_polygon_test_tb;

    localparam int         CB          = pip_pkg::COORD_BITS;
    localparam int         CNT_W       = pip_pkg::VCOUNT_W;
    localparam int         MAX_V       = pip_pkg::MAX_VERTICES;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         TARGET_REQS = 500;
    localparam int         DRAIN_WAIT  = MAX_V + 20;

    typedef struct packed {
        logic             in_poly;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_poly_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_action;
    logic signed [CB-1:0] i_coord_x;
    logic signed [CB-1:0] i_coord_y;
    logic                 o_done;
    logic                 o_inside_res;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_vertex_count;

    // polygon model state
    longint       poly_x [MAX_V];
    longint       poly_y [MAX_V];
    int           poly_count;
    t_poly_answer pending_answers [$];
    t_poly_answer want;

    int idle_pct;
    int cycle_count;
    int mismatches;
    int n_requests;
    int n_counted;
    int n_checked;
    int n_hits;
    int n_refused;
    int n_degen;

    point_in_polygon_test uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_done         (o_done),
        .o_inside_res   (o_inside_res),
        .o_status       (o_status),
        .o_vertex_count (o_vertex_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("point_in_polygon_test_tb: FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // update the model table and queue the answer for one accepted request
    task automatic model_request(input logic [1:0] act,
                                 input logic signed [CB-1:0] x,
                                 input logic signed [CB-1:0] y);
        t_poly_answer ans;
        longint       px, py, xi, yi, xj, yj, dy, lhs, rhs;
        int           j;
        logic         flag;
        ans = '0;
        px  = x;
        py  = y;
        case (act)
            pip_pkg::ACT_CLEAR: poly_count = 0;
            pip_pkg::ACT_APPEND: begin
                if (poly_count >= MAX_V) begin
                    ans.status = pip_pkg::ST_FULL;
                    n_refused++;
                end else begin
                    poly_x[poly_count] = px;
                    poly_y[poly_count] = py;
                    poly_count++;
                end
            end
            pip_pkg::ACT_QUERY: begin
                if (poly_count < pip_pkg::MIN_VERTICES) begin
                    ans.status = pip_pkg::ST_DEGEN;
                    n_degen++;
                end else begin
                    flag = 1'b0;
                    j    = poly_count - 1;
                    for (int i = 0; i < poly_count; i++) begin
                        xi = poly_x[i];
                        yi = poly_y[i];
                        xj = poly_x[j];
                        yj = poly_y[j];
                        // edge straddles the ray; exact cross-multiplied crossing test
                        if ((yi > py) != (yj > py)) begin
                            dy  = yj - yi;
                            lhs = (px - xi) * dy;
                            rhs = (xj - xi) * (py - yi);
                            if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
                                flag = ~flag;
                        end
                        j = i;
                    end
                    ans.in_poly = flag;
                    n_hits += flag;
                end
            end
            default: ;
        endcase
        ans.count = poly_count[CNT_W-1:0];
        pending_answers.insert(pending_answers.size(), ans);
    endtask

    task automatic send_request(input logic [1:0] act,
                                input logic signed [CB-1:0] x,
                                input logic signed [CB-1:0] y);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_action  <= act;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (o_busy);
        model_request(act, x, y);
        n_requests++;
        if (act != ACT_UNUSED)
            n_counted++;
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // span 0 means the full 16-bit range
    function automatic logic signed [CB-1:0] pick_coord(input int span);
        logic [31:0] raw;
        if (span == 0)
            raw = $urandom();
        else
            raw = $urandom_range(0, 2 * span) - span;
        return raw[CB-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_checked++;
            if (pending_answers.size() == 0) begin
                note_mismatch($sformatf("unexpected result inside=%0d status=%0d count=%0d",
                              o_inside_res, o_status, o_vertex_count));
            end else begin
                want = pending_answers.pop_front();
                if (o_inside_res !== want.in_poly)
                    note_mismatch($sformatf("request %0d inside: expected %0d, got %0d",
                                  n_checked, want.in_poly, o_inside_res));
                if (o_status !== want.status)
                    note_mismatch($sformatf("request %0d status: expected %0d, got %0d",
                                  n_checked, want.status, o_status));
                if (o_vertex_count !== want.count)
                    note_mismatch($sformatf("request %0d count: expected %0d, got %0d",
                                  n_checked, want.count, o_vertex_count));
            end
        end
    end

    // extremes of the coordinate range, short tables, unused code, points on edges and corners
    task automatic test_directed();
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_APPEND, -16'sd32768, -16'sd32768);
        send_request(pip_pkg::ACT_APPEND, 16'sd32767, -16'sd32768);
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_APPEND, 16'sd32767, 16'sd32767);
        send_request(pip_pkg::ACT_APPEND, -16'sd32768, 16'sd32767);
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_QUERY,  -16'sd32768, -16'sd32768);
        send_request(pip_pkg::ACT_QUERY,  16'sd32767, 16'sd0);
        send_request(pip_pkg::ACT_QUERY,  -16'sd32768, 16'sd0);
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd32767);
        send_request(ACT_UNUSED,          -16'sd1, -16'sd1);
        send_request(pip_pkg::ACT_CLEAR,  -16'sd1, 16'sd32767);
        // right triangle with a horizontal base
        send_request(pip_pkg::ACT_APPEND, 16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_APPEND, 16'sd10, 16'sd0);
        send_request(pip_pkg::ACT_APPEND, 16'sd0, 16'sd10);
        send_request(pip_pkg::ACT_QUERY,  16'sd1, 16'sd1);
        send_request(pip_pkg::ACT_QUERY,  16'sd5, 16'sd5);
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd5);
        send_request(pip_pkg::ACT_QUERY,  -16'sd1, 16'sd5);
        send_request(pip_pkg::ACT_QUERY,  16'sd3, 16'sd0);
        send_request(pip_pkg::ACT_QUERY,  16'sd0, 16'sd10);
        send_request(ACT_UNUSED,          16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_CLEAR,  16'sd0, 16'sd0);
        send_request(pip_pkg::ACT_QUERY,  16'sd1, 16'sd1);
    endtask

    // one polygon: optional clear, vertices, then queries with some noise mixed in
    task automatic run_polygon_set(input int n_vertices, input int n_queries);
        int span;
        int pick;
        logic signed [CB-1:0] qx, qy;
        case ($urandom_range(0, 2))
            0: span = 8;
            1: span = 1000;
            default: span = 0;
        endcase
        if ($urandom_range(0, 7) != 0)
            send_request(pip_pkg::ACT_CLEAR, pick_coord(0), pick_coord(0));
        for (int k = 0; k < n_vertices; k++) begin
            if ($urandom_range(0, 29) == 0)
                send_request(ACT_UNUSED, pick_coord(0), pick_coord(0));
            send_request(pip_pkg::ACT_APPEND, pick_coord(span), pick_coord(span));
        end
        for (int q = 0; q < n_queries; q++) begin
            qx = pick_coord(span);
            qy = pick_coord(span);
            // land on a vertex row or column now and then
            if (poly_count > 0 && $urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, poly_count - 1);
                if ($urandom_range(0, 1)) qx = poly_x[pick][CB-1:0];
                if ($urandom_range(0, 1)) qy = poly_y[pick][CB-1:0];
            end
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_UNUSED, pick_coord(0), pick_coord(0));
            send_request(pip_pkg::ACT_QUERY, qx, qy);
        end
    endtask

    function automatic int pick_vertex_total();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom_range(0, 2);
        if (r < 90) return $urandom_range(3, 12);
        if (r < 98) return $urandom_range(13, 40);
        return $urandom_range(MAX_V, MAX_V + 3);
    endfunction

    task automatic test_full_table();
        idle_pct = 20;
        run_polygon_set(MAX_V + 3, 4);
        send_request(pip_pkg::ACT_APPEND, pick_coord(0), pick_coord(0));
        send_request(pip_pkg::ACT_CLEAR, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_polygons(input int upto);
        while (n_counted < upto) begin
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            run_polygon_set(pick_vertex_total(), $urandom_range(1, 8));
        end
    endtask

    task automatic test_pause_until_drained();
        idle_pct = 0;
        run_polygon_set($urandom_range(3, 8), 3);
        wait_drained();
        run_polygon_set($urandom_range(3, 8), 3);
    endtask

    task automatic test_back_to_back(input int upto);
        idle_pct = 0;
        while (n_counted < upto)
            run_polygon_set(pick_vertex_total(), $urandom_range(1, 8));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_action   = pip_pkg::ACT_CLEAR;
        i_coord_x  = '0;
        i_coord_y  = '0;
        poly_count = 0;
        idle_pct   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random_polygons(TARGET_REQS * 3 / 5);
        test_pause_until_drained();
        test_random_polygons(TARGET_REQS * 4 / 5);
        test_back_to_back(TARGET_REQS);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("summary: %0d requests, %0d answers checked, %0d inside hits",
                 n_requests, n_checked, n_hits);
        $display("summary: %0d refused appends, %0d short-table queries, %0d mismatches",
                 n_refused, n_degen, mismatches);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("point_in_polygon_test_tb: PASS");
        end else begin
            $display("point_in_polygon_test_tb: FAIL");
        end
        $finish;
    end

endmodule
